[sv/bcfl_pkg.sv]
package bcfl_pkg;

    localparam int POOL_CHUNKS_DEF = 256;

    localparam int FUNC_W  = 2;
    localparam int ID_W    = 8;
    localparam int FIELD_W = 9;
    localparam int FAIL_W  = 32;
    localparam int CFG_W   = 9;
    localparam int STAT_W  = 2;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 64;

    localparam logic [FUNC_W-1:0] FN_ACQUIRE = 2'd0;
    localparam logic [FUNC_W-1:0] FN_RECYCLE = 2'd1;
    localparam logic [FUNC_W-1:0] FN_REFILL  = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_WAIT    = 2'd1;
    localparam logic [STAT_W-1:0] ST_REFUSED = 2'd2;
    localparam logic [STAT_W-1:0] ST_BAD_ID  = 2'd3;

    localparam logic [1:0] POL_DROP = 2'd0;
    localparam logic [1:0] POL_WAIT = 2'd1;
    localparam logic [1:0] POL_GROW = 2'd2;

    localparam logic CFG_IDX_BUDGET = 1'b0;
    localparam logic CFG_IDX_POLICY = 1'b1;

    localparam logic [CFG_W-1:0] BUDGET_RESET = 9'd256;

    // controller to datapath
    typedef struct packed {
        logic               load_in;
        logic               set_res;
        logic [STAT_W-1:0]  res_code;
        logic               pop;
        logic               grant_new;
        logic               fail;
        logic               push_cid;
        logic               fill_push;
        logic               out_load;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic               level_zero;
        logic               stack_full;
        logic               can_create;
        logic               cid_valid;
        logic               fill_go;
        logic               policy_wait;
        logic               out_free;
    } dp_stat_t;

endpackage

[sv/bcfl_ctrl.sv]
module bcfl_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  bcfl_pkg::dp_stat_t    stat,
    output bcfl_pkg::ctrl_cmd_t   cmd
);

    typedef enum logic [1:0] {
        IDLE,
        EXEC,
        FILL,
        RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        s_tready = (state_reg == IDLE) || ((state_reg == RESULT) && stat.out_free);
    end

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = EXEC;
                end
            end
            EXEC: begin
                cmd.set_res = 1'b1;
                cmd.res_code = bcfl_pkg::ST_OK;
                state_next  = RESULT;
                unique case (stat.func)
                    bcfl_pkg::FN_ACQUIRE: begin
                        priority if (!stat.level_zero) begin
                            cmd.pop = 1'b1;
                        end else if (stat.can_create) begin
                            cmd.grant_new = 1'b1;
                        end else begin
                            cmd.fail     = 1'b1;
                            cmd.res_code = stat.policy_wait ? bcfl_pkg::ST_WAIT
                                                            : bcfl_pkg::ST_REFUSED;
                        end
                    end
                    bcfl_pkg::FN_RECYCLE: begin
                        priority if (!stat.cid_valid) begin
                            cmd.res_code = bcfl_pkg::ST_BAD_ID;
                        end else if (stat.stack_full) begin
                            cmd.res_code = bcfl_pkg::ST_REFUSED;
                        end else begin
                            cmd.push_cid = 1'b1;
                        end
                    end
                    bcfl_pkg::FN_REFILL: begin
                        state_next = FILL;
                    end
                    default: begin
                        cmd.res_code = bcfl_pkg::ST_REFUSED;
                    end
                endcase
            end
            FILL: begin
                // one created chunk pushed per cycle
                if (stat.fill_go) begin
                    cmd.fill_push = 1'b1;
                end else begin
                    state_next = RESULT;
                end
            end
            RESULT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    if (s_tvalid) begin
                        cmd.load_in = 1'b1;
                        state_next  = EXEC;
                    end else begin
                        state_next = IDLE;
                    end
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[sv/bcfl_dpath.sv]
module bcfl_dpath #(
    parameter int POOL_CHUNKS = bcfl_pkg::POOL_CHUNKS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic [bcfl_pkg::S_TDATA_W-1:0]       s_tdata,
    input  logic [bcfl_pkg::FUNC_W-1:0]          s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [bcfl_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic [bcfl_pkg::STAT_W-1:0]          m_tuser,
    input  logic                                 cfg_wr_en,
    input  logic                                 cfg_index,
    input  logic [bcfl_pkg::CFG_W-1:0]           cfg_wdata,
    input  bcfl_pkg::ctrl_cmd_t                  cmd,
    output bcfl_pkg::dp_stat_t                   stat
);

    localparam int CNT_W  = $clog2(POOL_CHUNKS + 1);
    localparam int ADDR_W = $clog2(POOL_CHUNKS);
    localparam int CMP_W  = (CNT_W > bcfl_pkg::FIELD_W) ? CNT_W : bcfl_pkg::FIELD_W;
    localparam logic [CNT_W-1:0] POOL_CNT = CNT_W'(POOL_CHUNKS);
    localparam int ID_W   = bcfl_pkg::ID_W;
    localparam int FLD_W  = bcfl_pkg::FIELD_W;
    localparam int FAIL_W = bcfl_pkg::FAIL_W;

    logic [ID_W-1:0] stack_mem [POOL_CHUNKS];

    logic [bcfl_pkg::CFG_W-1:0]  budget_reg;
    logic [1:0]                  policy_reg;

    logic [bcfl_pkg::FUNC_W-1:0] func_reg;
    logic [ID_W-1:0]             cid_reg;
    logic [FLD_W-1:0]            target_reg;

    logic [CNT_W-1:0]            level_reg;
    logic [CNT_W-1:0]            level_next;
    logic [CNT_W-1:0]            created_reg;
    logic [CNT_W-1:0]            created_next;
    logic [FAIL_W-1:0]           failed_reg;
    logic [FAIL_W-1:0]           failed_next;

    logic [ID_W-1:0]             rd_data_reg;
    logic [bcfl_pkg::STAT_W-1:0] res_status_reg;
    logic [ID_W-1:0]             res_granted_reg;
    logic                        from_mem_reg;

    logic                        m_tvalid_reg;
    logic [bcfl_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic [bcfl_pkg::STAT_W-1:0] m_tuser_reg;

    logic [ID_W-1:0]             new_id;
    logic [ADDR_W-1:0]           push_addr;
    logic [ADDR_W-1:0]           pop_addr;
    logic                        push_en;
    logic [ID_W-1:0]             push_data;
    logic [ID_W-1:0]             granted_out;
    logic                        full_now;
    logic                        create_ok;

    assign new_id    = ID_W'(created_reg);
    assign push_addr = level_reg[ADDR_W-1:0];
    assign pop_addr  = ADDR_W'(level_reg - CNT_W'(1));
    assign push_en   = cmd.push_cid || cmd.fill_push;
    assign push_data = cmd.push_cid ? cid_reg : new_id;

    assign full_now  = (level_reg >= POOL_CNT);
    assign create_ok = (created_reg < POOL_CNT)
                       && ((policy_reg == bcfl_pkg::POL_GROW)
                           || (CMP_W'(created_reg) < CMP_W'(budget_reg)));

    // status toward the controller
    always_comb begin
        stat.func        = func_reg;
        stat.level_zero  = (level_reg == '0);
        stat.stack_full  = full_now;
        stat.can_create  = create_ok;
        stat.cid_valid   = (CMP_W'(cid_reg) < CMP_W'(created_reg));
        stat.fill_go     = (CMP_W'(level_reg) < CMP_W'(target_reg))
                           && !full_now && create_ok;
        stat.policy_wait = (policy_reg == bcfl_pkg::POL_WAIT);
        stat.out_free    = !m_tvalid_reg || m_tready;
    end

    always_comb begin
        level_next   = level_reg;
        created_next = created_reg;
        failed_next  = failed_reg;
        if (cmd.pop) begin
            level_next = level_reg - CNT_W'(1);
        end
        if (push_en) begin
            level_next = level_reg + CNT_W'(1);
        end
        if (cmd.grant_new || cmd.fill_push) begin
            created_next = created_reg + CNT_W'(1);
        end
        if (cmd.fail && (failed_reg != '1)) begin
            failed_next = failed_reg + FAIL_W'(1);
        end
    end

    assign granted_out = from_mem_reg ? rd_data_reg : res_granted_reg;

    always_ff @(posedge aclk) begin
        if (push_en) begin
            stack_mem[push_addr] <= push_data;
        end
        if (cmd.pop) begin
            rd_data_reg <= stack_mem[pop_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            func_reg   <= s_tuser;
            cid_reg    <= s_tdata[ID_W-1:0];
            target_reg <= s_tdata[ID_W +: FLD_W];
        end
        if (cmd.set_res) begin
            res_status_reg  <= cmd.res_code;
            res_granted_reg <= cmd.grant_new ? new_id : '0;
        end
        if (cmd.out_load) begin
            m_tuser_reg <= res_status_reg;
            m_tdata_reg <= {6'd0, failed_reg, FLD_W'(created_reg), FLD_W'(level_reg),
                            granted_out};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            budget_reg   <= bcfl_pkg::BUDGET_RESET;
            policy_reg   <= bcfl_pkg::POL_DROP;
            level_reg    <= '0;
            created_reg  <= '0;
            failed_reg   <= '0;
            from_mem_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    bcfl_pkg::CFG_IDX_BUDGET: budget_reg <= cfg_wdata;
                    bcfl_pkg::CFG_IDX_POLICY: policy_reg <= cfg_wdata[1:0];
                    default: ;
                endcase
            end
            level_reg   <= level_next;
            created_reg <= created_next;
            failed_reg  <= failed_next;
            if (cmd.set_res) begin
                from_mem_reg <= cmd.pop;
            end
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

[sv/budgeted_chunk_free_list.sv]
// acquire, recycle and unknown ops: decode/stack access, then output load, which waits
// while the result side does not keep up
// refill: decode, then one stack write per cycle, then output load
// the result register lets the next word be accepted in the cycle the result is loaded
// aresetn (synchronous, active low) empties the stack, clears the counters, sets budget
// to 256 and policy to drop; stack storage is not cleared and needs no clearing pass
module budgeted_chunk_free_list #(
    parameter int POOL_CHUNKS = bcfl_pkg::POOL_CHUNKS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // chunk_id[7:0], fill_target[16:8], zero pad
    input  logic [bcfl_pkg::S_TDATA_W-1:0]       s_tdata,
    // func[1:0]
    input  logic [bcfl_pkg::FUNC_W-1:0]          s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // granted_id[7:0], ready_now[16:8], created_now[25:17], failures_now[57:26], zero pad
    output logic [bcfl_pkg::M_TDATA_W-1:0]       m_tdata,
    // status[1:0]
    output logic [bcfl_pkg::STAT_W-1:0]          m_tuser,
    input  logic                                 cfg_wr_en,
    input  logic                                 cfg_index,
    input  logic [bcfl_pkg::CFG_W-1:0]           cfg_wdata
);

    bcfl_pkg::ctrl_cmd_t cmd;
    bcfl_pkg::dp_stat_t  stat;

    bcfl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bcfl_dpath #(
        .POOL_CHUNKS (POOL_CHUNKS)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
